// ===== design/assert_macros.svh =====
// Assertion macros for the port-level verification checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define AALR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define AALR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/aalr_pkg.sv =====
// Package for the antialiased line rasteriser: sequencer state type and
// fixed output widths. No dependencies.
package aalr_pkg;

  localparam int OUT_W   = 11;
  localparam int ALPHA_W = 8;
  localparam logic [OUT_W-1:0] STEP_SAT = '1;

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_SWAP       = 9'b000000010,
    S_ORDER      = 9'b000000100,
    S_DIV        = 9'b000001000,
    S_ENDS       = 9'b000010000,
    S_HOLD_FIRST = 9'b000100000,
    S_MUL        = 9'b001000000,
    S_COL        = 9'b010000000,
    S_HOLD       = 9'b100000000
  } state_t;

endpackage

// ===== design/antialiased_line_rasterizer.sv =====
// Wu antialiased line rasteriser: start transactions set up a line through a
// bit-serial gradient divider, advance transactions emit one column each while
// a line is active. Depends on aalr_pkg.
// Start: the swap, order and divide states run before the endpoint pair is packed;
//   the restoring divider retires one quotient bit a cycle (unit slope if dx is 0).
// Advance: a multiply state registers the alpha product, a column state packs it.
// Next transaction is taken the cycle after the last result is accepted, so none
//   is taken while a line setup or column is still in progress.
// Reset (synchronous, rst_n low) returns to idle with no active line.
module antialiased_line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16,
  parameter int ALPHA_MAX  = 255
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [COORD_BITS-1:0]         in_start_x,
  input  logic [COORD_BITS-1:0]         in_start_y,
  input  logic [COORD_BITS-1:0]         in_end_x,
  input  logic [COORD_BITS-1:0]         in_end_y,
  input  logic                          in_draw_enable,
  input  logic                          in_count_enable,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [aalr_pkg::OUT_W-1:0]    out_first_x,
  output logic [aalr_pkg::OUT_W-1:0]    out_first_y,
  output logic [aalr_pkg::OUT_W-1:0]    out_second_x,
  output logic [aalr_pkg::OUT_W-1:0]    out_second_y,
  output logic [aalr_pkg::ALPHA_W-1:0]  out_first_alpha,
  output logic [aalr_pkg::ALPHA_W-1:0]  out_second_alpha,
  output logic                          out_visible,
  output logic                          out_last,
  output logic [aalr_pkg::OUT_W-1:0]    out_step_total
);
  import aalr_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int FW  = FRAC_BITS;
  localparam int IW  = CW + FW + 1;
  localparam int QW  = FW + 1;
  localparam int SW  = FW + 2;
  localparam int DCW = $clog2(QW);
  localparam int AW  = $clog2(ALPHA_MAX + 1);
  localparam int PW  = FW + AW;
  localparam logic [AW-1:0]  AMAX     = AW'(ALPHA_MAX);
  localparam logic [AW-1:0]  AHALF    = AW'(ALPHA_MAX >> 1);
  localparam logic [DCW-1:0] CNT_LAST = DCW'(QW - 1);
  localparam logic [QW-1:0]  Q_ONE    = QW'(1) << FW;

  state_t state_r, state_nxt;

  logic          line_active_r, steep_r, draw_r, count_r;
  logic [OUT_W-1:0] step_count_r, step_new;

  logic [CW-1:0] ax_r, ay_r, bx_r, by_r;
  logic [CW-1:0] dx_r;
  logic          dyneg_r;
  logic [CW:0]   rem_r;
  logic [QW-1:0] quo_r;
  logic [DCW-1:0] cnt_r;
  logic signed [SW-1:0] slope_r;
  logic [IW-1:0] intercept_r;
  logic [CW:0]   column_r;
  logic [CW-1:0] end_column_r;
  logic [PW-1:0] prod_r;

  logic [OUT_W-1:0]   out_first_x_r, out_first_y_r, out_second_x_r, out_second_y_r;
  logic [ALPHA_W-1:0] out_first_alpha_r, out_second_alpha_r;
  logic               out_visible_r, out_last_r;
  logic [OUT_W-1:0]   out_step_total_r;

  logic in_acc, out_acc;

  // axis swap
  logic [CW-1:0] adx, ady_raw, sw_ax, sw_ay, sw_bx, sw_by;
  logic          steep;
  // end ordering
  logic [CW-1:0] or_ax, or_ay, or_bx, or_by;
  logic          dyneg;
  // divider step
  logic [CW:0]   div_sh, div_rem;
  logic          div_ge;
  // shared intercept adder
  logic signed [SW-1:0] slope_calc, add_slope;
  logic [IW-1:0]        add_base, add_clamped;
  logic signed [IW:0]   add_sum;
  // column
  logic [CW:0]   ip, nxt_ip, col_inc;
  logic          fin;
  logic [AW-1:0] a1, a2;
  logic [AW:0]   a1_wide;
  // pair packer
  logic             load_out;
  logic [CW:0]      pk_col, pk_minor;
  logic [AW-1:0]    pk_a1, pk_a2;
  logic             pk_last;
  logic [OUT_W-1:0] pk_steps, pk_major11, pk_minor11, pk_minor1_11;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_HOLD_FIRST) || (state_r == S_HOLD);

  always_comb begin
    adx     = (bx_r > ax_r) ? bx_r - ax_r : ax_r - bx_r;
    ady_raw = (by_r > ay_r) ? by_r - ay_r : ay_r - by_r;
    steep   = ady_raw > adx;
    sw_ax   = steep ? ay_r : ax_r;
    sw_ay   = steep ? ax_r : ay_r;
    sw_bx   = steep ? by_r : bx_r;
    sw_by   = steep ? bx_r : by_r;
  end

  always_comb begin
    if (ax_r > bx_r) begin
      or_ax = bx_r;
      or_ay = by_r;
      or_bx = ax_r;
      or_by = ay_r;
    end else begin
      or_ax = ax_r;
      or_ay = ay_r;
      or_bx = bx_r;
      or_by = by_r;
    end
    dyneg = or_ay > or_by;
  end

  always_comb begin
    div_sh  = (cnt_r == '0) ? rem_r : {rem_r[CW-1:0], 1'b0};
    div_ge  = div_sh >= {1'b0, dx_r};
    div_rem = div_ge ? div_sh - {1'b0, dx_r} : div_sh;
  end

  always_comb begin
    slope_calc = dyneg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    if (state_r == S_ENDS) begin
      add_base  = IW'({ay_r, {FW{1'b0}}});
      add_slope = slope_calc;
    end else begin
      add_base  = intercept_r;
      add_slope = slope_r;
    end
    add_sum     = $signed({1'b0, add_base}) + (IW+1)'(add_slope);
    add_clamped = add_sum[IW] ? '0 : add_sum[IW-1:0];
  end

  always_comb begin
    ip      = intercept_r[IW-1:FW];
    nxt_ip  = add_clamped[IW-1:FW];
    col_inc = column_r + 1'b1;
    fin     = col_inc >= {1'b0, end_column_r};
    a2      = prod_r[PW-1:FW];
    a1_wide = {1'b0, AMAX} - {1'b0, a2} - (AW+1)'(prod_r[FW-1:0] != '0);
    a1      = a1_wide[AW-1:0];
    if (count_r && (nxt_ip != ip) && (step_count_r != STEP_SAT)) begin
      step_new = step_count_r + 1'b1;
    end else begin
      step_new = step_count_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    pk_col    = '0;
    pk_minor  = '0;
    pk_a1     = AHALF;
    pk_a2     = '0;
    pk_last   = 1'b0;
    pk_steps  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_mode) begin
            state_nxt = S_SWAP;
          end else if (line_active_r) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_SWAP:  state_nxt = S_ORDER;
      S_ORDER: state_nxt = S_DIV;
      S_DIV: begin
        if (dx_r == '0 || cnt_r == CNT_LAST) begin
          state_nxt = S_ENDS;
        end
      end
      S_ENDS: begin
        load_out  = 1'b1;
        pk_col    = {1'b0, ax_r};
        pk_minor  = {1'b0, ay_r};
        state_nxt = S_HOLD_FIRST;
      end
      S_HOLD_FIRST: begin
        if (out_acc) begin
          load_out  = 1'b1;
          pk_col    = {1'b0, bx_r};
          pk_minor  = {1'b0, by_r};
          pk_last   = !line_active_r;
          state_nxt = S_HOLD;
        end
      end
      S_MUL: state_nxt = S_COL;
      S_COL: begin
        load_out  = 1'b1;
        pk_col    = column_r;
        pk_minor  = ip;
        pk_a1     = a1;
        pk_a2     = a2;
        pk_last   = fin;
        pk_steps  = step_new;
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pk_major11   = OUT_W'(pk_col);
    pk_minor11   = OUT_W'(pk_minor);
    pk_minor1_11 = OUT_W'({1'b0, pk_minor} + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      line_active_r <= 1'b0;
      steep_r       <= 1'b0;
      draw_r        <= 1'b0;
      count_r       <= 1'b0;
      step_count_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_acc && !in_mode) begin
        draw_r  <= in_draw_enable;
        count_r <= in_count_enable;
      end
      if (state_r == S_SWAP) begin
        steep_r <= steep;
      end
      if (state_r == S_ENDS) begin
        line_active_r <= ({1'b0, ax_r} + 1'b1) < {1'b0, bx_r};
        step_count_r  <= '0;
      end
      if (state_r == S_COL) begin
        line_active_r <= !fin;
        step_count_r  <= step_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !in_mode) begin
          ax_r <= in_start_x;
          ay_r <= in_start_y;
          bx_r <= in_end_x;
          by_r <= in_end_y;
        end
      end
      S_SWAP: begin
        ax_r <= sw_ax;
        ay_r <= sw_ay;
        bx_r <= sw_bx;
        by_r <= sw_by;
      end
      S_ORDER: begin
        ax_r    <= or_ax;
        ay_r    <= or_ay;
        bx_r    <= or_bx;
        by_r    <= or_by;
        dx_r    <= or_bx - or_ax;
        dyneg_r <= dyneg;
        rem_r   <= {1'b0, (dyneg ? or_ay - or_by : or_by - or_ay)};
        quo_r   <= '0;
        cnt_r   <= '0;
      end
      S_DIV: begin
        if (dx_r == '0) begin
          quo_r <= Q_ONE;
        end else begin
          rem_r <= div_rem;
          quo_r <= {quo_r[QW-2:0], div_ge};
          cnt_r <= cnt_r + 1'b1;
        end
      end
      S_ENDS: begin
        slope_r      <= slope_calc;
        intercept_r  <= add_clamped;
        column_r     <= {1'b0, ax_r} + 1'b1;
        end_column_r <= bx_r;
      end
      S_MUL: begin
        prod_r <= intercept_r[FW-1:0] * AMAX;
      end
      S_COL: begin
        intercept_r <= add_clamped;
        column_r    <= col_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (steep_r) begin
        out_first_x_r  <= pk_minor11;
        out_first_y_r  <= pk_major11;
        out_second_x_r <= pk_minor1_11;
        out_second_y_r <= pk_major11;
      end else begin
        out_first_x_r  <= pk_major11;
        out_first_y_r  <= pk_minor11;
        out_second_x_r <= pk_major11;
        out_second_y_r <= pk_minor1_11;
      end
      out_first_alpha_r  <= ALPHA_W'(pk_a1);
      out_second_alpha_r <= ALPHA_W'(pk_a2);
      out_visible_r      <= draw_r;
      out_last_r         <= pk_last;
      out_step_total_r   <= pk_steps;
    end
  end

  assign out_first_x      = out_first_x_r;
  assign out_first_y      = out_first_y_r;
  assign out_second_x     = out_second_x_r;
  assign out_second_y     = out_second_y_r;
  assign out_first_alpha  = out_first_alpha_r;
  assign out_second_alpha = out_second_alpha_r;
  assign out_visible      = out_visible_r;
  assign out_last         = out_last_r;
  assign out_step_total   = out_step_total_r;

endmodule

// ===== design/aalr_checker.sv =====
// Port-level checker for the antialiased line rasteriser, bound to the top level.
// Depends on aalr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aalr_checker #(
  parameter int COORD_BITS = 10
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [aalr_pkg::OUT_W-1:0]    out_first_x,
  input logic [aalr_pkg::OUT_W-1:0]    out_first_y,
  input logic [aalr_pkg::OUT_W-1:0]    out_second_x,
  input logic [aalr_pkg::OUT_W-1:0]    out_second_y,
  input logic [aalr_pkg::ALPHA_W-1:0]  out_first_alpha,
  input logic [aalr_pkg::ALPHA_W-1:0]  out_second_alpha,
  input logic                          out_last,
  input logic [aalr_pkg::OUT_W-1:0]    out_step_total
);
  import aalr_pkg::*;

  logic [OUT_W-1:0] coord_lim;
  assign coord_lim = OUT_W'(COORD_BITS);

  // result transaction never overlaps an open input slot
  `AALR_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall, "input ready while result pending")

  // accepted input never produces a result in the very next cycle
  `AALR_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall && coord_lim != '0, !out_valid, "result too early after input")

  // both pixels of a pair share the major coordinate
  `AALR_ASSERT_NOW(a_pair_column, out_valid, (out_first_x == out_second_x) || (out_first_y == out_second_y), "pair not on one column")

  // stalled result stays valid and holds first coordinates, alphas, last and step total
  `AALR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_first_x) && $stable(out_first_y) && $stable(out_first_alpha) && $stable(out_second_alpha) && $stable(out_last) && $stable(out_step_total), "stalled result changed")

endmodule

bind antialiased_line_rasterizer aalr_checker #(.COORD_BITS(COORD_BITS)) u_aalr_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for antialiased_line_rasterizer: directed and random line
// transactions, an in-file Wu line predictor, random idling on both channels.
// Depends on aalr_pkg and the rasteriser RTL.
module testbench;
  import aalr_pkg::*;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS = 16;
  localparam int ALPHA_MAX = 255;
  localparam bit MODE_START = 1'b0;
  localparam bit MODE_ADVANCE = 1'b1;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam longint FRAC_ONE = 64'sd1 <<< FRAC_BITS;

  typedef struct {
    bit mode;
    bit [COORD_BITS-1:0] ax, ay, bx, by;
    bit draw, count;
  } line_cmd_t;

  typedef struct {
    bit [OUT_W-1:0] fx, fy, sx, sy;
    bit [ALPHA_W-1:0] fa, sa;
    bit vis, last;
    bit [OUT_W-1:0] steps;
  } pixel_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [COORD_BITS-1:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic in_draw_enable = 1'b0;
  logic in_count_enable = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_W-1:0] out_first_x, out_first_y, out_second_x, out_second_y, out_step_total;
  logic [ALPHA_W-1:0] out_first_alpha, out_second_alpha;
  logic out_visible, out_last;

  antialiased_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .ALPHA_MAX (ALPHA_MAX)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_draw_enable  (in_draw_enable),
    .in_count_enable (in_count_enable),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_x     (out_first_x),
    .out_first_y     (out_first_y),
    .out_second_x    (out_second_x),
    .out_second_y    (out_second_y),
    .out_first_alpha (out_first_alpha),
    .out_second_alpha(out_second_alpha),
    .out_visible     (out_visible),
    .out_last        (out_last),
    .out_step_total  (out_step_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  line_cmd_t cmd_backlog[$];
  pixel_pair_t pairs_due[$];
  line_cmd_t next_cmd, taken_cmd;
  bit cmd_taken = 1'b0;
  int total_cmds = 1;
  int sent_cmds = 0;
  int predicted_cmds = 0;
  int pairs_checked = 0;
  int lines_closed = 0;
  int mismatches = 0;
  int busy_items = 0;
  int cycles = 0;

  // predictor state
  bit line_on = 1'b0, line_steep = 1'b0, line_draw = 1'b0, line_count = 1'b0;
  longint col_next = 0, col_end = 0, slope_q = 0, icept_q = 0, stair_steps = 0;

  function automatic longint add_slope(longint v);
    longint s;
    s = v + slope_q;
    return (s < 0) ? 64'sd0 : s;
  endfunction

  function automatic pixel_pair_t make_pair(longint col, longint minor, longint a1,
                                            longint a2, bit fin, longint steps);
    pixel_pair_t p;
    if (line_steep) begin
      p.fx = OUT_W'(minor);
      p.fy = OUT_W'(col);
      p.sx = OUT_W'(minor + 1);
      p.sy = OUT_W'(col);
    end else begin
      p.fx = OUT_W'(col);
      p.fy = OUT_W'(minor);
      p.sx = OUT_W'(col);
      p.sy = OUT_W'(minor + 1);
    end
    p.fa = ALPHA_W'(a1);
    p.sa = ALPHA_W'(a2);
    p.vis = line_draw;
    p.last = fin;
    p.steps = OUT_W'(steps);
    return p;
  endfunction

  function automatic void rasterise_cmd(line_cmd_t c);
    longint ax, ay, bx, by, t, dx, dy, adx, ady, ip, f, nxt, col;
    bit steep, fin;
    if (c.mode == MODE_START) begin
      ax = longint'(c.ax);
      ay = longint'(c.ay);
      bx = longint'(c.bx);
      by = longint'(c.by);
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? by - ay : ay - by;
      steep = ady > adx;
      if (steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = by - ay;
      if (dx == 0) begin
        slope_q = FRAC_ONE;
      end else begin
        t = (((dy < 0) ? -dy : dy) <<< FRAC_BITS) / dx;
        slope_q = (dy < 0) ? -t : t;
      end
      line_steep = steep;
      line_draw = c.draw;
      line_count = c.count;
      stair_steps = 0;
      icept_q = add_slope(ay <<< FRAC_BITS);
      col_next = ax + 1;
      col_end = bx;
      line_on = col_next < col_end;
      pairs_due.push_back(make_pair(ax, ay, longint'(ALPHA_MAX / 2), 64'sd0, 1'b0, 64'sd0));
      pairs_due.push_back(make_pair(bx, by, longint'(ALPHA_MAX / 2), 64'sd0, !line_on,
                                    64'sd0));
    end else if (line_on) begin
      ip = icept_q >>> FRAC_BITS;
      f = icept_q & (FRAC_ONE - 1);
      nxt = add_slope(icept_q);
      if (line_count && (nxt >>> FRAC_BITS) != ip && stair_steps < longint'(STEP_SAT))
        stair_steps++;
      icept_q = nxt;
      col = col_next;
      col_next = col + 1;
      fin = col_next >= col_end;
      if (fin) line_on = 1'b0;
      pairs_due.push_back(make_pair(col, ip, ((FRAC_ONE - f) * ALPHA_MAX) >>> FRAC_BITS,
                                    (f * ALPHA_MAX) >>> FRAC_BITS, fin, stair_steps));
    end
  endfunction

  // phase 0: sender 14 / receiver 50, phase 1: swapped, phase 2: no idling
  function automatic int idle_pct(int done, bit receiver);
    int phase;
    phase = (done * 3) / total_cmds;
    if (phase == 0) return receiver ? 50 : 14;
    if (phase == 1) return receiver ? 14 : 50;
    return 0;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_start(int ax, int ay, int bx, int by, bit draw, bit count);
    line_cmd_t c;
    c.mode = MODE_START;
    c.ax = COORD_BITS'(ax);
    c.ay = COORD_BITS'(ay);
    c.bx = COORD_BITS'(bx);
    c.by = COORD_BITS'(by);
    c.draw = draw;
    c.count = count;
    cmd_backlog.push_back(c);
  endtask

  task automatic add_advance(int n);
    line_cmd_t c;
    repeat (n) begin
      c.mode = MODE_ADVANCE;
      c.ax = COORD_BITS'($urandom);
      c.ay = COORD_BITS'($urandom);
      c.bx = COORD_BITS'($urandom);
      c.by = COORD_BITS'($urandom);
      c.draw = 1'($urandom_range(1));
      c.count = 1'($urandom_range(1));
      cmd_backlog.push_back(c);
    end
  endtask

  task automatic queue_line(int major_max);
    int ax, ay, bx, by, dmaj, dmin, n, extra, r, t;
    dmaj = $urandom_range(major_max);
    dmin = $urandom_range(dmaj);
    ax = $urandom_range(1023);
    ay = $urandom_range(1023);
    bx = ($urandom_range(1) && ax + dmaj <= 1023) || ax < dmaj ? ax + dmaj : ax - dmaj;
    by = ($urandom_range(1) && ay + dmin <= 1023) || ay < dmin ? ay + dmin : ay - dmin;
    if ($urandom_range(1)) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    add_start(ax, ay, bx, by, 1'($urandom_range(1)), 1'($urandom_range(1)));
    n = (dmaj >= 2) ? dmaj - 1 : 0;
    extra = 0;
    r = $urandom_range(99);
    if (r < 10)
      n = $urandom_range(n);
    else if (r < 20)
      extra = $urandom_range(1, 3);
    add_advance(n + extra);
    busy_items += 1 + n;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= in_valid && !in_stall;
      taken_cmd <= '{in_mode, in_start_x, in_start_y, in_end_x, in_end_y,
                     in_draw_enable, in_count_enable};
      if (in_valid && !in_stall) sent_cmds++;
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct(sent_cmds, 1'b0)) begin
          next_cmd = cmd_backlog.pop_front();
          in_mode <= next_cmd.mode;
          in_start_x <= next_cmd.ax;
          in_start_y <= next_cmd.ay;
          in_end_x <= next_cmd.bx;
          in_end_y <= next_cmd.by;
          in_draw_enable <= next_cmd.draw;
          in_count_enable <= next_cmd.count;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // predict the transaction taken last edge before checking this edge's result
  always @(posedge clk) begin
    pixel_pair_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (cmd_taken) begin
        rasterise_cmd(taken_cmd);
        predicted_cmds++;
      end
      if (out_valid && !out_stall) begin
        if (pairs_due.size() == 0) begin
          $error("unexpected result at (%0d,%0d)", out_first_x, out_first_y);
          mismatches++;
        end else begin
          want = pairs_due.pop_front();
          check_field("first_x", longint'(want.fx), longint'(out_first_x));
          check_field("first_y", longint'(want.fy), longint'(out_first_y));
          check_field("second_x", longint'(want.sx), longint'(out_second_x));
          check_field("second_y", longint'(want.sy), longint'(out_second_y));
          check_field("first_alpha", longint'(want.fa), longint'(out_first_alpha));
          check_field("second_alpha", longint'(want.sa), longint'(out_second_alpha));
          check_field("visible", longint'(want.vis), longint'(out_visible));
          check_field("last", longint'(want.last), longint'(out_last));
          check_field("step_total", longint'(want.steps), longint'(out_step_total));
          pairs_checked++;
          if (want.last) lines_closed++;
        end
      end
      out_stall <= $urandom_range(99) < idle_pct(predicted_cmds, 1'b1);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int r;
    // advance with no line, single points, extremes, restart, no-interior line
    add_advance(1);
    add_start(0, 0, 0, 0, 1'b1, 1'b1);
    add_advance(1);
    add_start(1023, 1023, 1023, 1023, 1'b0, 1'b0);
    add_start(0, 0, 1023, 1023, 1'b1, 1'b1);
    add_advance(2);
    add_start(1023, 0, 0, 1023, 1'b0, 1'b1);
    add_advance(1);
    add_start(5, 1023, 5, 0, 1'b1, 1'b0);
    add_advance(1);
    add_start(1023, 7, 0, 7, 1'b1, 1'b1);
    add_advance(1);
    add_start(0, 6, 5, 3, 1'b1, 1'b1);
    add_advance(5);
    add_start(3, 3, 4, 4, 1'b0, 1'b1);
    add_advance(1);
    add_start(2, 0, 4, 5, 1'b1, 1'b1);
    add_advance(4);
    while (busy_items < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 8) begin
        if ($urandom_range(1)) begin
          add_advance(1);
        end else begin
          add_start($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(1023), 1'($urandom_range(1)), 1'($urandom_range(1)));
          busy_items++;
        end
      end else begin
        queue_line((r < 15) ? 150 : 12);
      end
    end
    total_cmds = cmd_backlog.size();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (cmd_backlog.size() != 0 || in_valid || cmd_taken || pairs_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pairs_due.size() != 0) begin
      $error("%0d expected results never arrived", pairs_due.size());
      mismatches += pairs_due.size();
    end
    $display("Sent %0d line transactions, checked %0d pixel pairs over %0d completed lines",
             sent_cmds, pairs_checked, lines_closed);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
